// ===== rtl/bm3_pkg.sv =====
// Package with the shared constants, register codes and types of the 3x3 morphology block.
package bm3_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = 12;
  localparam int MASK_W      = 9;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SLOT_W      = 2;
  localparam int SLOTS       = 4;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 13'd480;
  localparam logic [MASK_W-1:0]      MASK_RESET   = 9'h1FF;
  localparam logic [PIX_W-1:0]       PIX_FULL     = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_OP_MODE      = 2'd2,
    REG_STRUCT_MASK  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] row_slot;
    logic              top_ok;
    logic              bot_ok;
    logic              left_ok;
    logic              right_ok;
    logic              last;
    logic              mode;
    logic [MASK_W-1:0] mask;
  } centre_t;

  function automatic logic [PIX_W-1:0] target_pix(input logic mode);
    return mode ? PIX_FULL : '0;
  endfunction

endpackage

// ===== rtl/bm3_if.sv =====
// Interfaces of the pixel input, result output and configuration write channels.
interface bm3_in_if;
  logic                         valid;
  logic                         ready;
  logic [bm3_pkg::PIX_W-1:0]    pixel_in;
  logic                         drain;
  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

interface bm3_out_if;
  logic                         valid;
  logic                         ready;
  logic [bm3_pkg::PIX_W-1:0]    pixel_out;
  logic                         frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface bm3_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bm3_pkg::CFG_IDX_W-1:0]   index;
  logic [bm3_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bm3_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module bm3_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/bm3_ctrl.sv =====
// Configuration registers, raster counters and result scheduling of the morphology block.
module bm3_ctrl #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bm3_in_if.sink                       in_bus,
  bm3_cfg_if.sink                      cfg_bus,
  input  logic                         win_ready,
  output logic                         emit,
  output bm3_pkg::centre_t             centre,
  output logic                         wr_en,
  output logic [bm3_pkg::SLOT_W-1:0]   wr_slot,
  output logic [COL_W-1:0]             wr_col,
  output logic                         wr_flag,
  output logic [COL_W-1:0]             rd_col
);

  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int PRIME_W = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W   = bm3_pkg::ROW_W;
  localparam int HGT_W   = bm3_pkg::HEIGHT_W;

  logic [bm3_pkg::WIDTH_REG_W-1:0] cfg_width_r;
  logic [HGT_W-1:0]                cfg_height_r;
  logic                            cfg_mode_r;
  logic [bm3_pkg::MASK_W-1:0]      cfg_mask_r;

  logic [WID_W-1:0]                cur_w_r;
  logic [HGT_W-1:0]                cur_h_r;
  logic                            cur_mode_r;
  logic [bm3_pkg::MASK_W-1:0]      cur_mask_r;

  logic                            active_r, active_nxt;
  logic                            done_r, done_nxt;
  logic [COL_W-1:0]                in_col_r, in_col_nxt;
  logic [ROW_W-1:0]                in_row_r, in_row_nxt;
  logic [COL_W-1:0]                out_col_r, out_col_nxt;
  logic [ROW_W-1:0]                out_row_r, out_row_nxt;
  logic [PRIME_W-1:0]              prime_r, prime_nxt;

  logic [31:0]                     w32, h32;
  logic [WID_W-1:0]                sat_w, eff_w, w_m1;
  logic [HGT_W-1:0]                sat_h, eff_h, h_m1;
  logic                            eff_mode;
  logic [bm3_pkg::MASK_W-1:0]      eff_mask;
  logic                            accept, is_pix;
  logic                            in_last_col, in_last, prime_full;
  logic                            out_last_col, out_last_row, frame_last;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = win_ready;
  assign accept        = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= bm3_pkg::WIDTH_RESET;
      cfg_height_r <= bm3_pkg::HEIGHT_RESET;
      cfg_mode_r   <= 1'b0;
      cfg_mask_r   <= bm3_pkg::MASK_RESET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (bm3_pkg::cfg_reg_t'(cfg_bus.index))
        bm3_pkg::REG_FRAME_WIDTH: begin
          cfg_width_r <= cfg_bus.data[bm3_pkg::WIDTH_REG_W-1:0];
        end
        bm3_pkg::REG_FRAME_HEIGHT: begin
          cfg_height_r <= cfg_bus.data[HGT_W-1:0];
        end
        bm3_pkg::REG_OP_MODE: begin
          cfg_mode_r <= cfg_bus.data[0];
        end
        bm3_pkg::REG_STRUCT_MASK: begin
          cfg_mask_r <= cfg_bus.data[bm3_pkg::MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The geometry is clamped to the supported range and frozen for the whole frame.
  always_comb begin
    w32 = 32'(cfg_width_r);
    h32 = 32'(cfg_height_r);
    if (w32 == 32'd0) begin
      sat_w = WID_W'(1);
    end else if (w32 > 32'(MAX_WIDTH)) begin
      sat_w = WID_W'(MAX_WIDTH);
    end else begin
      sat_w = WID_W'(w32);
    end
    if (h32 == 32'd0) begin
      sat_h = HGT_W'(1);
    end else if (h32 > 32'(bm3_pkg::MAX_HEIGHT)) begin
      sat_h = HGT_W'(bm3_pkg::MAX_HEIGHT);
    end else begin
      sat_h = HGT_W'(h32);
    end
  end

  assign eff_w    = active_r ? cur_w_r : sat_w;
  assign eff_h    = active_r ? cur_h_r : sat_h;
  assign eff_mode = active_r ? cur_mode_r : cfg_mode_r;
  assign eff_mask = active_r ? cur_mask_r : cfg_mask_r;
  assign w_m1     = eff_w - WID_W'(1);
  assign h_m1     = eff_h - HGT_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_w_r    <= eff_w;
      cur_h_r    <= eff_h;
      cur_mode_r <= eff_mode;
      cur_mask_r <= eff_mask;
    end
  end

  assign is_pix       = !in_bus.drain && !done_r;
  assign in_last_col  = WID_W'(in_col_r) == w_m1;
  assign in_last      = in_last_col && (HGT_W'(in_row_r) == h_m1);
  assign prime_full   = prime_r >= (PRIME_W'(eff_w) + PRIME_W'(1));
  assign out_last_col = WID_W'(out_col_r) == w_m1;
  assign out_last_row = HGT_W'(out_row_r) == h_m1;
  assign frame_last   = out_last_col && out_last_row;

  // A result is due once the pixel below and to the right of its centre has arrived.
  assign emit = accept && (is_pix ? (in_last || prime_full) : done_r);

  always_comb begin
    active_nxt  = active_r;
    done_nxt    = done_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    prime_nxt   = prime_r;
    if (accept && is_pix) begin
      active_nxt = 1'b1;
      if (in_last_col) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (!prime_full) begin
        prime_nxt = prime_r + 1'b1;
      end
      if (in_last) begin
        done_nxt = 1'b1;
      end
    end
    if (emit) begin
      if (frame_last) begin
        active_nxt  = 1'b0;
        done_nxt    = 1'b0;
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        prime_nxt   = '0;
      end else if (out_last_col) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      done_r    <= 1'b0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      prime_r   <= '0;
    end else begin
      active_r  <= active_nxt;
      done_r    <= done_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      prime_r   <= prime_nxt;
    end
  end

  assign wr_en   = accept && is_pix;
  assign wr_slot = in_row_r[bm3_pkg::SLOT_W-1:0];
  assign wr_col  = in_col_r;
  assign wr_flag = in_bus.pixel_in == bm3_pkg::target_pix(eff_mode);

  // At the end of a row the next row's first column is fetched instead.
  assign rd_col = out_last_col ? '0 : out_col_r + 1'b1;

  always_comb begin
    centre.row_slot = out_row_r[bm3_pkg::SLOT_W-1:0];
    centre.top_ok   = out_row_r != '0;
    centre.bot_ok   = !out_last_row;
    centre.left_ok  = out_col_r != '0;
    centre.right_ok = !out_last_col;
    centre.last     = frame_last;
    centre.mode     = eff_mode;
    centre.mask     = eff_mask;
  end

endmodule

// ===== rtl/bm3_window.sv =====
// Flag line memories, 3x3 window columns, neighbourhood test and output register.
module bm3_window #(
  parameter int MAX_WIDTH = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         emit,
  input  bm3_pkg::centre_t             centre,
  input  logic                         wr_en,
  input  logic [bm3_pkg::SLOT_W-1:0]   wr_slot,
  input  logic [COL_W-1:0]             wr_col,
  input  logic                         wr_flag,
  input  logic [COL_W-1:0]             rd_col,
  output logic                         win_ready,
  bm3_out_if.source                    out_bus
);

  localparam int SLOTS  = bm3_pkg::SLOTS;
  localparam int SLOT_W = bm3_pkg::SLOT_W;

  logic [SLOTS-1:0]           ram_q;
  logic [SLOTS-1:0]           fwd_hit_r;
  logic                       fwd_flag_r;
  logic [SLOTS-1:0]           right_col;
  logic [SLOTS-1:0]           left_r;
  logic [SLOTS-1:0]           mid_r, mid_nxt;
  logic [COL_W-1:0]           mid_col_r, mid_col_nxt;

  logic                       s1_valid_r;
  bm3_pkg::centre_t           s1_centre_r;
  logic [COL_W-1:0]           s1_col_r;
  logic                       s1_adv, s1_move;

  logic                       out_valid_r;
  logic [bm3_pkg::PIX_W-1:0]  out_pix_r;
  logic                       out_end_r;

  logic                       hit;
  logic [bm3_pkg::PIX_W-1:0]  result_pix;

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    bm3_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en && (wr_slot == SLOT_W'(s))),
      .wr_addr (wr_col),
      .wr_data (wr_flag),
      .rd_en   (emit),
      .rd_addr (rd_col),
      .rd_data (ram_q[s])
    );
  end

  // A flag written in the same cycle as the read of its column is taken from the write.
  always_ff @(posedge clk) begin
    if (emit) begin
      for (int s = 0; s < SLOTS; s++) begin
        fwd_hit_r[s] <= wr_en && (wr_slot == SLOT_W'(s)) && (wr_col == rd_col);
      end
      fwd_flag_r <= wr_flag;
      s1_centre_r <= centre;
      s1_col_r    <= rd_col;
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      right_col[s] = fwd_hit_r[s] ? fwd_flag_r : ram_q[s];
    end
  end

  assign s1_adv    = !out_valid_r || out_bus.ready;
  assign s1_move   = s1_valid_r && s1_adv;
  assign win_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (emit) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // The centre column is kept equal to its memory column, including writes made after the fetch.
  always_comb begin
    mid_nxt     = mid_r;
    mid_col_nxt = mid_col_r;
    if (s1_move) begin
      mid_nxt     = right_col;
      mid_col_nxt = s1_col_r;
    end
    if (wr_en && (wr_col == mid_col_nxt)) begin
      mid_nxt[wr_slot] = wr_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_col_r <= '0;
    end else begin
      mid_col_r <= mid_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
    if (s1_move) begin
      left_r <= mid_r;
    end
  end

  always_comb begin
    logic [SLOT_W-1:0] slot;
    logic              flag;
    logic              ok;
    hit = 1'b0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        slot = s1_centre_r.row_slot + SLOT_W'(dy + 3);
        if (dx == 0) begin
          flag = left_r[slot];
        end else if (dx == 1) begin
          flag = mid_r[slot];
        end else begin
          flag = right_col[slot];
        end
        ok = (dy != 0 || s1_centre_r.top_ok) && (dy != 2 || s1_centre_r.bot_ok) &&
             (dx != 0 || s1_centre_r.left_ok) && (dx != 2 || s1_centre_r.right_ok);
        hit = hit || (ok && s1_centre_r.mask[dy * 3 + dx] && flag);
      end
    end
    result_pix = hit ? bm3_pkg::target_pix(s1_centre_r.mode)
                     : ~bm3_pkg::target_pix(s1_centre_r.mode);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r <= result_pix;
      out_end_r <= s1_centre_r.last;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.pixel_out = out_pix_r;
  assign out_bus.frame_end = out_end_r;

endmodule

// ===== rtl/binary_morphology_3x3_top.sv =====
// Top level of the 3x3 binary dilation and erosion block on a raster pixel stream.
//
// Words enter on in_bus in raster order: a pixel, or a drain word that carries no pixel.
// Each pixel is reduced to a match flag and stored in four one-bit line memories, one per
// row modulo four. The result for a position leaves on out_bus as 0 or 255, with frame_end
// set on the last result of the frame. A result becomes due with the word that brings the
// pixel one row and one column after its centre; once the whole frame is in, every further
// word, pixel or drain, releases the next pending result until the frame is complete.
// A due result passes through the registered memory read, held in the compute stage, and
// then through the output register before it appears on out_bus.
// The block takes one word per cycle; a word is turned away only while both the compute
// stage and the output register hold a result and out_bus.ready is low.
// The configuration port always accepts; new geometry, mode and mask take effect with the
// next frame. Reset clears the counters and the pipeline; the line memories need no
// clearing, as only flags written in the current frame are read.
module binary_morphology_3x3_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  bm3_in_if.sink      in_bus,
  bm3_out_if.source   out_bus,
  bm3_cfg_if.sink     cfg_bus
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                         emit;
  bm3_pkg::centre_t             centre;
  logic                         wr_en;
  logic [bm3_pkg::SLOT_W-1:0]   wr_slot;
  logic [COL_W-1:0]             wr_col;
  logic                         wr_flag;
  logic [COL_W-1:0]             rd_col;
  logic                         win_ready;

  bm3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_bus   (cfg_bus),
    .win_ready (win_ready),
    .emit      (emit),
    .centre    (centre),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_col    (wr_col),
    .wr_flag   (wr_flag),
    .rd_col    (rd_col)
  );

  bm3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .centre    (centre),
    .wr_en     (wr_en),
    .wr_slot   (wr_slot),
    .wr_col    (wr_col),
    .wr_flag   (wr_flag),
    .rd_col    (rd_col),
    .win_ready (win_ready),
    .out_bus   (out_bus)
  );

endmodule

// ===== rtl/bm3_checker.sv =====
// Port-level assertion checker for the morphology block and its bind to the top level.
module bm3_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bm3_pkg::PIX_W-1:0]  pixel_out,
  input logic                       frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(frame_end))
    else $error("result word changed while stalled");

  a_out_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pixel_out == '0 || pixel_out == bm3_pkg::PIX_FULL))
    else $error("result pixel is neither black nor white");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused while the output register is empty");

endmodule

bind binary_morphology_3x3_top bm3_checker u_bm3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .pixel_out (out_bus.pixel_out),
  .frame_end (out_bus.frame_end)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the 3x3 binary dilation and erosion block, with its own predictor.
module tb;
  import bm3_pkg::*;

  localparam int LINE_MAX = 1024;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             fend;
  } morph_res_t;

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;
  int   mismatch_count = 0;
  int   items_done = 0;

  bm3_in_if  in_bus();
  bm3_out_if out_bus();
  bm3_cfg_if cfg_bus();

  binary_morphology_3x3_top #(.MAX_WIDTH(LINE_MAX)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Predictor state: match flags, frame counters, written and latched settings.
  bit                     flag_mem [SLOTS][LINE_MAX];
  int unsigned            col_pos = 0, row_pos = 0, res_count = 0, pix_count = 0;
  bit                     frame_in = 1'b0;
  logic [WIDTH_REG_W-1:0] width_reg = WIDTH_RESET;
  logic [HEIGHT_W-1:0]    height_reg = HEIGHT_RESET;
  logic                   mode_reg = 1'b0;
  logic [MASK_W-1:0]      mask_reg = MASK_RESET;
  int unsigned            act_w = 640, act_h = 480;
  logic                   act_mode = 1'b0;
  logic [MASK_W-1:0]      act_mask = MASK_RESET;
  morph_res_t             due_pixels [$];
  logic [PIX_W-1:0]       pixel_script [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_bus.ready <= calm || ($urandom_range(99) >= 30);
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] window_result(int unsigned k);
    int unsigned r, c;
    int          rr, cc;
    bit          hit;
    logic [PIX_W-1:0] target;
    r = k / act_w;
    c = k % act_w;
    hit = 1'b0;
    target = act_mode ? PIX_FULL : 8'h00;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        rr = int'(r) + dy - 1;
        cc = int'(c) + dx - 1;
        if (rr >= 0 && cc >= 0 && rr < int'(act_h) && cc < int'(act_w) &&
            act_mask[dy*3+dx] && flag_mem[rr % SLOTS][cc]) begin
          hit = 1'b1;
        end
      end
    end
    return hit ? target : PIX_FULL - target;
  endfunction

  function automatic void morph_step(logic [PIX_W-1:0] pix, logic drn);
    int unsigned      total;
    bit               due;
    logic [PIX_W-1:0] target;
    morph_res_t       res;
    if (pix_count == 0 && res_count == 0 && !frame_in) begin
      act_w = clamp_dim(32'(width_reg), LINE_MAX);
      act_h = clamp_dim(32'(height_reg), MAX_HEIGHT);
      act_mode = mode_reg;
      act_mask = mask_reg;
    end
    total = act_w * act_h;
    target = act_mode ? PIX_FULL : 8'h00;
    due = 1'b0;
    if (!drn && !frame_in) begin
      flag_mem[row_pos % SLOTS][col_pos] = (pix == target);
      col_pos++;
      if (col_pos >= act_w) begin
        col_pos = 0;
        row_pos++;
      end
      pix_count++;
      if (pix_count >= total) frame_in = 1'b1;
      if (frame_in) due = res_count < total;
      else due = pix_count >= res_count + act_w + 2;
    end else if (frame_in) begin
      due = res_count < total;
    end
    if (!due) return;
    res.pix = window_result(res_count);
    res_count++;
    res.fend = (res_count >= total);
    if (res.fend) begin
      col_pos = 0;
      row_pos = 0;
      res_count = 0;
      pix_count = 0;
      frame_in = 1'b0;
    end
    due_pixels.push_back(res);
  endfunction

  always @(posedge clk) begin
    morph_res_t want;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_FRAME_WIDTH:  width_reg = cfg_bus.data[WIDTH_REG_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_bus.data[HEIGHT_W-1:0];
          REG_OP_MODE:      mode_reg = cfg_bus.data[0];
          REG_STRUCT_MASK:  mask_reg = cfg_bus.data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) morph_step(in_bus.pixel_in, in_bus.drain);
      if (out_bus.valid && out_bus.ready) begin
        if (due_pixels.size() == 0) begin
          $error("unexpected word: pixel_out %0d frame_end %0b",
                 out_bus.pixel_out, out_bus.frame_end);
          mismatch_count++;
        end else begin
          want = due_pixels.pop_front();
          if (out_bus.pixel_out !== want.pix) begin
            $error("pixel_out: expected %0d, actual %0d", want.pix, out_bus.pixel_out);
            mismatch_count++;
          end
          if (out_bus.frame_end !== want.fend) begin
            $error("frame_end: expected %0b, actual %0b", want.fend, out_bus.frame_end);
            mismatch_count++;
          end
        end
      end
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return 8'h00;
    if (r < 8) return PIX_FULL;
    return 8'($urandom_range(255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [PIX_W-1:0] pix, logic drn);
    if (!calm && $urandom_range(99) < 30) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.pixel_in <= pix;
    in_bus.drain    <= drn;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (due_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] m, logic [CFG_DATA_W-1:0] k);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_OP_MODE, m);
    write_reg(REG_STRUCT_MASK, k);
  endtask

  // Feeds the rest of the current frame, then flushes its tail with drains and stray pixels.
  task automatic run_frame(int unsigned drain_pct, int unsigned tail_pix_pct);
    bit               started;
    logic [PIX_W-1:0] pix;
    started = 1'b0;
    do begin
      if ($urandom_range(99) < drain_pct) begin
        send_word(8'($urandom_range(255)), 1'b1);
      end else begin
        pix = (pixel_script.size() != 0) ? pixel_script.pop_front() : rand_pixel();
        send_word(pix, 1'b0);
        started = 1'b1;
        items_done++;
      end
    end while (!(frame_in || (started && pix_count == 0)));
    while (frame_in) begin
      if ($urandom_range(99) < tail_pix_pct) send_word(rand_pixel(), 1'b0);
      else send_word(8'($urandom_range(255)), 1'b1);
      items_done++;
    end
  endtask

  task automatic test_pixel_extremes();
    for (int m = 0; m < 2; m++) begin
      set_frame(13'd3, 13'd3, 13'(m), 13'h1FF);
      pixel_script = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'h00};
      run_frame(0, 0);
    end
  endtask

  task automatic test_mask_patterns();
    logic [MASK_W-1:0] masks [4] = '{9'h000, 9'h010, 9'h1EF, 9'h145};
    foreach (masks[i]) begin
      set_frame(13'd3, 13'd2, 13'(i % 2), 13'(masks[i]));
      run_frame(0, 0);
    end
  endtask

  task automatic test_drain_and_tail();
    set_frame(13'd4, 13'd3, 13'd1, 13'h0BA);
    run_frame(30, 100);
  endtask

  task automatic test_config_mid_frame();
    set_frame(13'd5, 13'd2, 13'd0, 13'h1FF);
    repeat (3) send_word(rand_pixel(), 1'b0);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_OP_MODE, 13'd1);
    run_frame(10, 50);
    run_frame(10, 50);
  endtask

  task automatic test_size_limits();
    set_frame(13'd0, 13'd0, 13'h1FFE, 13'h1E00);
    run_frame(0, 0);
    set_frame(13'h1FFF, 13'd1, 13'h1FFF, 13'h1FFF);
    calm = 1'b1;
    run_frame(5, 50);
    calm = 1'b0;
  endtask

  task automatic test_random_frames();
    logic [CFG_DATA_W-1:0] w, h, k;
    int unsigned           r;
    while (items_done < 1300) begin
      if ($urandom_range(99) < 40) begin
        r = $urandom_range(9);
        w = (r < 8) ? 13'($urandom_range(10, 1)) :
            (r < 9) ? 13'($urandom_range(40, 11)) : 13'd0;
        w[CFG_DATA_W-1:WIDTH_REG_W] = 2'($urandom_range(3));
        r = $urandom_range(9);
        h = (r < 8) ? 13'($urandom_range(8, 1)) :
            (r < 9) ? 13'($urandom_range(20, 9)) : 13'd0;
        r = $urandom_range(99);
        k = (r < 15) ? 13'h000 : (r < 30) ? 13'h1FF : 13'($urandom_range(511));
        k[CFG_DATA_W-1:MASK_W] = 4'($urandom_range(15));
        set_frame(w, h, 13'($urandom_range(8191)), k);
      end
      repeat ($urandom_range(2)) send_word(8'($urandom_range(255)), 1'b1);
      run_frame($urandom_range(20), $urandom_range(100));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.pixel_in = '0;
    in_bus.drain = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_FRAME_WIDTH;
    cfg_bus.data = '0;
    out_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_pixel_extremes();
    test_mask_patterns();
    test_drain_and_tail();
    test_config_mid_frame();
    test_size_limits();
    test_random_frames();
    in_bus.valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
